@@ design/ceed_pkg.sv @@
`timescale 1ns / 1ps

package ceed_pkg;

	// Default window half-widths.
	localparam int SMOOTH_HALF_DEF = 4;
	localparam int EDGE_HALF_DEF   = 7;

	// Field widths.
	localparam int HEIGHT_W    = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_ADDR_W  = 2;
	localparam int OUT_TDATA_W = 8;

	// Register reset values.
	localparam logic [15:0] RISE_THRESHOLD_RST   = 16'd50;
	localparam logic [3:0]  SMOOTH_MIN_COUNT_RST = 4'd4;
	localparam logic [4:0]  START_MIN_SCORE_RST  = 5'd2;
	localparam logic [3:0]  END_MIN_COUNT_RST    = 4'd6;

	// Register indexes.
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_RISE_THRESHOLD   = 2'd0,
		REG_SMOOTH_MIN_COUNT = 2'd1,
		REG_START_MIN_SCORE  = 2'd2,
		REG_END_MIN_COUNT    = 2'd3
	} reg_idx_t;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic [15:0] rise_threshold;
		logic [3:0]  smooth_min_count;
		logic [4:0]  start_min_score;
		logic [3:0]  end_min_count;
	} cfg_t;

	// Control that goes with one scoring request.
	typedef struct packed {
		logic left;
		logic edges;
		logic done;
	} score_ctl_t;

	// One result beat.
	typedef struct packed {
		logic scan_done;
		logic end_flag;
		logic start_flag;
		logic elevated;
	} res_t;

endpackage

@@ design/ceed_front.sv @@
`timescale 1ns / 1ps

module ceed_front #(
	parameter int SMOOTH_HALF = ceed_pkg::SMOOTH_HALF_DEF,
	parameter int EDGE_HALF   = ceed_pkg::EDGE_HALF_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ceed_pkg::cfg_t                         cfg,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [ceed_pkg::HEIGHT_W-1:0]          in_height,
	input  logic                                   in_left,
	input  logic                                   in_last,
	output logic                                   push,
	input  logic                                   push_ready,
	output logic [3*EDGE_HALF+SMOOTH_HALF:0]       raw_win,
	output logic [3*EDGE_HALF:0]                   valid_win,
	output ceed_pkg::score_ctl_t                   ctl
);

	localparam int LAG = 2 * EDGE_HALF;
	localparam int SW  = $clog2(LAG + 2);
	localparam int RW  = 3 * EDGE_HALF + SMOOTH_HALF + 1;
	localparam int VW  = 3 * EDGE_HALF + 1;
	localparam int HW  = ceed_pkg::HEIGHT_W;

	logic [RW-1:0] raw_q, raw_base, raw_next, raw_load;
	logic [VW-1:0] valid_q, valid_base, valid_next, valid_load;
	logic [HW-1:0] prior_q;
	logic [SW-1:0] seen_q, seen_base, seen_next, shamt;
	logic [SW-1:0] cnt_q;
	logic          dir_q, dir_base, first_q, pend_q, drain_edges_q;
	logic          have_prior, edges_next, accept, advance;
	logic [HW+1:0] hx, px, tx, up_d, dn_d;
	logic          up_hit, dn_hit;

	// Handshake: a pending normal result must leave before the windows move.
	assign in_ready = (cnt_q == '0) && (!pend_q || push_ready);
	assign accept   = in_valid && in_ready;
	assign push     = pend_q || (cnt_q != '0);
	assign advance  = push && push_ready;

	assign raw_win   = raw_q;
	assign valid_win = valid_q;
	assign ctl.left  = dir_q;
	assign ctl.edges = pend_q ? 1'b1 : drain_edges_q;
	assign ctl.done  = (cnt_q == SW'(1));

	// Window state as seen by the incoming point; a new scan starts empty.
	always_comb begin
		raw_base   = first_q ? '0 : raw_q;
		valid_base = first_q ? '0 : valid_q;
		seen_base  = first_q ? '0 : seen_q;
		dir_base   = first_q ? in_left : dir_q;
		have_prior = (seen_base != '0);
	end

	// Height steps against the previous point, in signed arithmetic.
	always_comb begin
		hx     = {{2{in_height[HW-1]}}, in_height};
		px     = {{2{prior_q[HW-1]}}, prior_q};
		tx     = {2'b00, cfg.rise_threshold};
		up_d   = hx - px;
		dn_d   = px - hx;
		up_hit = $signed(up_d) > $signed(tx);
		dn_hit = $signed(dn_d) > $signed(tx);
	end

	// Next window contents; a left scan marks the previous point.
	always_comb begin
		raw_next    = raw_base << 1;
		raw_next[0] = !dir_base && have_prior && up_hit;
		raw_next[1] = raw_base[0] || (dir_base && have_prior && dn_hit);
		valid_next  = {valid_base[VW-2:0], 1'b1};
		seen_next   = (seen_base == SW'(LAG + 1)) ? seen_base : seen_base + SW'(1);
		edges_next  = (seen_next == SW'(LAG + 1));
		shamt       = SW'(LAG + 1) - seen_next;
		// At the final point, line the oldest pending point up with the center.
		raw_load    = in_last ? (raw_next << shamt) : raw_next;
		valid_load  = in_last ? (valid_next << shamt) : valid_next;
	end

	// Window, direction and drain control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q         <= '0;
			valid_q       <= '0;
			seen_q        <= '0;
			cnt_q         <= '0;
			dir_q         <= 1'b0;
			first_q       <= 1'b1;
			pend_q        <= 1'b0;
			drain_edges_q <= 1'b0;
		end else if (accept) begin
			raw_q         <= raw_load;
			valid_q       <= valid_load;
			seen_q        <= seen_next;
			dir_q         <= dir_base;
			first_q       <= in_last;
			pend_q        <= !in_last && edges_next;
			cnt_q         <= in_last ? seen_next : '0;
			drain_edges_q <= edges_next;
		end else if (advance) begin
			pend_q <= 1'b0;
			if (cnt_q != '0) begin
				raw_q   <= raw_q << 1;
				valid_q <= valid_q << 1;
				cnt_q   <= cnt_q - SW'(1);
			end
		end
	end

	// Previous height.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_q <= '0;
		end else if (accept) begin
			prior_q <= in_height;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= SW'(LAG + 1))
		else $error("drain count out of range");

	a_pend_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!(pend_q && (cnt_q != '0)))
		else $error("normal result pending during drain");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_last) |=> ((cnt_q != '0) && first_q && !in_ready))
		else $error("final point did not start a drain");

endmodule

@@ design/ceed_score.sv @@
`timescale 1ns / 1ps

module ceed_score #(
	parameter int SMOOTH_HALF = ceed_pkg::SMOOTH_HALF_DEF,
	parameter int EDGE_HALF   = ceed_pkg::EDGE_HALF_DEF
) (
	input  ceed_pkg::cfg_t                   cfg,
	input  logic [3*EDGE_HALF+SMOOTH_HALF:0] raw_win,
	input  logic [3*EDGE_HALF:0]             valid_win,
	input  ceed_pkg::score_ctl_t             ctl,
	output ceed_pkg::res_t                   res
);

	localparam int S   = SMOOTH_HALF;
	localparam int E   = EDGE_HALF;
	localparam int NF  = 2 * E + 1;
	localparam int RW  = 3 * E + S + 1;
	localparam int PW  = $clog2(2 * S + 2);
	localparam int PCW = PW + 4;
	localparam int CW  = $clog2(E + 2);
	localparam int XW  = CW + 6;

	logic [RW+S-1:0] raw_pad;
	logic [PW-1:0]   pc [NF];
	logic [NF-1:0]   sm;
	logic [CW-1:0]   lo_c, hi_c, mid_c, pos_c, neg_c, end_c;
	logic [XW-1:0]   score_x, smin_x;
	logic            start_hit, end_hit;

	// Zero padding stands for points beyond the newest one in the window.
	assign raw_pad = {raw_win, {S{1'b0}}};

	// Smoothed flags of the points around the center.
	always_comb begin
		for (int j = 0; j < NF; j++) begin
			pc[j] = '0;
			for (int d = 0; d < 2 * S + 1; d++) begin
				pc[j] = pc[j] + PW'(raw_pad[E + j + d]);
			end
			sm[j] = valid_win[E + j] && (PCW'(pc[j]) >= PCW'(cfg.smooth_min_count));
		end
	end

	// Counts on each side of the center.
	always_comb begin
		lo_c = '0;
		hi_c = '0;
		for (int j = 0; j < E; j++) begin
			lo_c = lo_c + CW'(sm[j]);
			hi_c = hi_c + CW'(sm[E + 1 + j]);
		end
		mid_c = CW'(sm[E]);
	end

	// Mirrored scores depend on the scan direction.
	always_comb begin
		if (ctl.left) begin
			pos_c = mid_c + hi_c;
			neg_c = lo_c;
			end_c = lo_c + mid_c;
		end else begin
			pos_c = lo_c + mid_c;
			neg_c = hi_c;
			end_c = mid_c + hi_c;
		end
		score_x   = XW'(pos_c) - XW'(neg_c);
		smin_x    = {{(XW - 5){cfg.start_min_score[4]}}, cfg.start_min_score};
		start_hit = $signed(score_x) >= $signed(smin_x);
		end_hit   = (XW'(end_c) >= XW'(cfg.end_min_count));
	end

	assign res.elevated   = sm[E];
	assign res.start_flag = ctl.edges && start_hit;
	assign res.end_flag   = ctl.edges && end_hit;
	assign res.scan_done  = ctl.done;

endmodule

@@ design/ceed_skid.sv @@
`timescale 1ns / 1ps

module ceed_skid (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           push_ready,
	input  ceed_pkg::res_t push_data,
	output logic           out_valid,
	input  logic           out_ready,
	output ceed_pkg::res_t out_data
);

	ceed_pkg::res_t mem_q [2];
	logic [1:0]     cnt_q;
	logic           wr_q, rd_q;
	logic           do_push, do_pop;

	// Two entries keep the ready toward the datapath a register.
	assign push_ready = (cnt_q != 2'd2);
	assign out_valid  = (cnt_q != 2'd0);
	assign out_data   = mem_q[rd_q];
	assign do_push    = push && push_ready;
	assign do_pop     = out_valid && out_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Result storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 2'd3) && ((cnt_q == 2'd1) == (wr_q != rd_q)))
		else $error("result buffer level and pointers disagree");

endmodule

@@ design/curb_elevation_edge_detector.sv @@
`timescale 1ns / 1ps

// Curb elevation edge detector.
// Input stream: one beat per point of a half-scan. s_tdata carries the signed
// height in 0.1 mm units, s_tuser the left/right direction (sampled on the
// first point only), s_tlast the final point of the half-scan.
// Output stream: one beat per point, in point order, with the smoothed
// elevation flag and the edge-start and edge-end flags; m_tlast marks the
// result of the scan's final point, which is the last one delivered.
// A point's result is released when the point 2*EDGE_HALF places later
// arrives; it is held in a register until the result buffer, which drives
// m_tvalid, takes it. Points are taken one per cycle while the buffer has
// room and no drain is running. On the final point of a scan the outstanding
// results (one per point still held, at most 2*EDGE_HALF+1) leave one per
// cycle while the buffer has room; s_tready stays low until the last has left.
// A stalled m_tready fills a two-beat result buffer and then holds off the
// input side. Scans of 2*EDGE_HALF points or fewer report no edges.
// The configuration port writes one register per cycle and must be used
// only while no scan is in flight. Reset loads the default thresholds,
// empties the windows and the result buffer; no clearing pass is needed.

module curb_elevation_edge_detector #(
	parameter int SMOOTH_HALF = ceed_pkg::SMOOTH_HALF_DEF,
	parameter int EDGE_HALF   = ceed_pkg::EDGE_HALF_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ceed_pkg::HEIGHT_W-1:0]      s_tdata,   // [15:0] height
	input  logic                               s_tuser,   // [0] left_scan
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ceed_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [0] elevated, [1] edge start,
	                                                      // [2] edge end, [7:3] zero
	output logic                               m_tlast,
	input  logic                               cfg_we,
	input  logic [ceed_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [ceed_pkg::CFG_W-1:0]         cfg_wdata
);

	localparam int RW = 3 * EDGE_HALF + SMOOTH_HALF + 1;
	localparam int VW = 3 * EDGE_HALF + 1;

	ceed_pkg::cfg_t       cfg_q;
	ceed_pkg::score_ctl_t ctl;
	ceed_pkg::res_t       res, out_res;
	logic [RW-1:0]        raw_win;
	logic [VW-1:0]        valid_win;
	logic                 push, push_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rise_threshold   <= ceed_pkg::RISE_THRESHOLD_RST;
			cfg_q.smooth_min_count <= ceed_pkg::SMOOTH_MIN_COUNT_RST;
			cfg_q.start_min_score  <= ceed_pkg::START_MIN_SCORE_RST;
			cfg_q.end_min_count    <= ceed_pkg::END_MIN_COUNT_RST;
		end else if (cfg_we) begin
			unique case (ceed_pkg::reg_idx_t'(cfg_addr))
				ceed_pkg::REG_RISE_THRESHOLD:   cfg_q.rise_threshold   <= cfg_wdata;
				ceed_pkg::REG_SMOOTH_MIN_COUNT: cfg_q.smooth_min_count <= cfg_wdata[3:0];
				ceed_pkg::REG_START_MIN_SCORE:  cfg_q.start_min_score  <= cfg_wdata[4:0];
				ceed_pkg::REG_END_MIN_COUNT:    cfg_q.end_min_count    <= cfg_wdata[3:0];
				default:                        cfg_q <= cfg_q;
			endcase
		end
	end

	// Point windows and drain sequencing.
	ceed_front #(
		.SMOOTH_HALF (SMOOTH_HALF),
		.EDGE_HALF   (EDGE_HALF)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_height  (s_tdata),
		.in_left    (s_tuser),
		.in_last    (s_tlast),
		.push       (push),
		.push_ready (push_ready),
		.raw_win    (raw_win),
		.valid_win  (valid_win),
		.ctl        (ctl)
	);

	// Smoothing and edge scoring at the window center.
	ceed_score #(
		.SMOOTH_HALF (SMOOTH_HALF),
		.EDGE_HALF   (EDGE_HALF)
	) u_score (
		.cfg       (cfg_q),
		.raw_win   (raw_win),
		.valid_win (valid_win),
		.ctl       (ctl),
		.res       (res)
	);

	// Result buffer toward the output stream.
	ceed_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_data  (res),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (out_res)
	);

	assign m_tdata = {5'b00000, out_res.end_flag, out_res.start_flag, out_res.elevated};
	assign m_tlast = out_res.scan_done;

	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:3] == 5'b00000))
		else $error("output padding bits set");

endmodule
